>>> rtl/multi_stack_bank_with_move_defines.svh
// ----------------------------------------------------------------------------
// Multi-stack bank assertion macros
// Shared concurrent assertion forms, clocked on i_clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef MULTI_STACK_BANK_WITH_MOVE_DEFINES_SVH
`define MULTI_STACK_BANK_WITH_MOVE_DEFINES_SVH

// Same-cycle implication.
`define MSBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define MSBM_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/msbm_pkg.sv
// ----------------------------------------------------------------------------
// Multi-stack bank package
// Field widths, default sizes, operation and status codes, command type.
// ----------------------------------------------------------------------------
package msbm_pkg;

    localparam int NUM_STACKS_DEF  = 16;
    localparam int STACK_DEPTH_DEF = 128;

    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int CNT_W   = 8;
    localparam int VAL_W   = 8;
    localparam int STS_W   = 3;

    // The stack fields address at most this many stacks.
    localparam int IDX_SPAN = 1 << IDX_W;

    localparam int CMDQ_DEPTH = 2;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH = 2'd0,
        OP_MOVE = 2'd1,
        OP_TOPS = 2'd2
    } t_op;

    typedef enum logic [STS_W-1:0] {
        STS_OK        = 3'd0,
        STS_BAD_INDEX = 3'd1,
        STS_FULL      = 3'd2,
        STS_TOO_FEW   = 3'd3,
        STS_NO_DATA   = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        CMD_PUSH,
        CMD_MOVE,
        CMD_TOPS,
        CMD_BAD
    } t_kind;

    typedef struct packed {
        t_kind              kind;
        logic [IDX_W-1:0]   src;
        logic [IDX_W-1:0]   dst;
        logic [CNT_W-1:0]   count;
        logic [VAL_W-1:0]   value;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PUSH,
        S_MV_SRC,
        S_MV_DST,
        S_MV_LOOP,
        S_MV_WB,
        S_RT_SCAN,
        S_RT_FLUSH
    } t_eng_state;

endpackage

>>> rtl/msbm_front.sv
// ----------------------------------------------------------------------------
// Multi-stack bank front end
// Takes an item off the command port, checks stack indexes and classifies it.
// ----------------------------------------------------------------------------
module msbm_front import msbm_pkg::*; #(
    parameter int NUM_STACKS = NUM_STACKS_DEF
) (
    input  logic              start,
    input  logic              i_full,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [IDX_W-1:0]  i_first_stack,
    input  logic [IDX_W-1:0]  i_second_stack,
    input  logic [CNT_W-1:0]  i_move_count,
    input  logic [VAL_W-1:0]  i_push_value,
    output logic              o_push,
    output t_cmd              o_cmd
);

    logic first_ok;
    logic second_ok;
    logic known_op;

    assign first_ok  = int'(i_first_stack) < NUM_STACKS;
    assign second_ok = int'(i_second_stack) < NUM_STACKS;

    always_comb begin
        o_cmd.src   = i_first_stack;
        o_cmd.dst   = i_second_stack;
        o_cmd.count = i_move_count;
        o_cmd.value = i_push_value;
        known_op    = 1'b1;
        unique case (t_op'(i_operation))
            OP_PUSH: o_cmd.kind = first_ok ? CMD_PUSH : CMD_BAD;
            OP_MOVE: o_cmd.kind = (first_ok && second_ok) ? CMD_MOVE : CMD_BAD;
            OP_TOPS: o_cmd.kind = CMD_TOPS;
            default: begin
                // The unused operation code is dropped here and never queued.
                o_cmd.kind = CMD_BAD;
                known_op   = 1'b0;
            end
        endcase
    end

    assign o_push = start && !i_full && known_op;

endmodule

>>> rtl/msbm_cmd_fifo.sv
// ----------------------------------------------------------------------------
// Multi-stack bank command queue
// Short register queue between the front end and the execution engine.
// ----------------------------------------------------------------------------
`include "multi_stack_bank_with_move_defines.svh"

module msbm_cmd_fifo import msbm_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_cmd  i_cmd,
    input  logic  i_pop,
    output t_cmd  o_cmd,
    output logic  o_full,
    output logic  o_empty
);

    localparam int PW = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
    localparam int CW = $clog2(CMDQ_DEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR  = PW'(CMDQ_DEPTH - 1);
    localparam logic [CW-1:0] FULL_CNT  = CW'(CMDQ_DEPTH);

    t_cmd           r_mem [CMDQ_DEPTH];
    logic [PW-1:0]  r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]  r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]  r_count, n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST_PTR) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST_PTR) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (!i_push && i_pop) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_cmd   = r_mem[r_rd_ptr];
    assign o_full  = (r_count == FULL_CNT);
    assign o_empty = (r_count == '0);

    `MSBM_ASSERT_IMP(a_no_pop_empty, i_pop, r_count != '0, "command queue popped while empty")

endmodule

>>> rtl/msbm_engine.sv
// ----------------------------------------------------------------------------
// Multi-stack bank execution engine
// Holds the stack store and fill counts and carries out queued commands.
// ----------------------------------------------------------------------------
`include "multi_stack_bank_with_move_defines.svh"

module msbm_engine import msbm_pkg::*; #(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_empty,
    output logic              o_pop,
    output logic              o_strobe,
    output logic [STS_W-1:0]  o_status,
    output logic [VAL_W-1:0]  o_top_value,
    output logic [IDX_W-1:0]  o_top_stack,
    output logic              o_last
);

    // Only stacks the index fields can reach get storage.
    localparam int NUM_ADDR  = (NUM_STACKS < IDX_SPAN) ? NUM_STACKS : IDX_SPAN;
    localparam int RW        = $clog2(NUM_ADDR);
    localparam int OW        = $clog2(STACK_DEPTH);
    localparam int FW        = $clog2(STACK_DEPTH + 1);
    localparam int AW        = RW + OW;
    localparam int MEM_DEPTH = NUM_ADDR << OW;
    localparam int XW        = ((FW > CNT_W) ? FW : CNT_W) + 1;
    localparam logic [FW-1:0] DEPTH_F  = FW'(STACK_DEPTH);
    localparam logic [XW-1:0] DEPTH_X  = XW'(STACK_DEPTH);
    localparam logic [RW-1:0] LAST_ROW = RW'(NUM_ADDR - 1);

    logic [VAL_W-1:0] mem [MEM_DEPTH];
    logic [VAL_W-1:0] r_rd_data;

    t_eng_state        r_state, n_state;
    t_cmd              r_cmd, n_cmd;
    logic [FW-1:0]     r_fill [NUM_ADDR];
    logic [FW-1:0]     n_fill [NUM_ADDR];
    logic [FW-1:0]     r_src_fill, n_src_fill;
    logic [FW-1:0]     r_dst_fill, n_dst_fill;
    logic [CNT_W-1:0]  r_left, n_left;
    logic              r_wr_pend, n_wr_pend;
    logic [RW-1:0]     r_scan, n_scan;
    logic              r_hit, n_hit;
    logic [RW-1:0]     r_hit_stack, n_hit_stack;
    logic              r_pend_valid, n_pend_valid;
    logic [VAL_W-1:0]  r_pend_value, n_pend_value;
    logic [RW-1:0]     r_pend_stack, n_pend_stack;

    logic              r_out_valid, n_out_valid;
    t_status           r_out_status, n_out_status;
    logic [VAL_W-1:0]  r_out_value, n_out_value;
    logic [IDX_W-1:0]  r_out_stack, n_out_stack;
    logic              r_out_last, n_out_last;

    logic [RW-1:0]     fill_idx;
    logic [FW-1:0]     fill_rd;
    logic [FW-1:0]     fill_dec;
    logic [FW-1:0]     src_dec;
    logic [RW-1:0]     src_row;
    logic [RW-1:0]     dst_row;
    logic [AW-1:0]     rd_addr;
    logic [AW-1:0]     wr_addr;
    logic [VAL_W-1:0]  wr_data;
    logic              we;
    logic [XW-1:0]     cnt_x;
    logic [XW-1:0]     dst_sum;

    assign src_row  = r_cmd.src[RW-1:0];
    assign dst_row  = r_cmd.dst[RW-1:0];
    assign fill_rd  = r_fill[fill_idx];
    assign fill_dec = fill_rd - FW'(1);
    assign src_dec  = r_src_fill - FW'(1);
    assign cnt_x    = XW'(r_cmd.count);
    assign dst_sum  = XW'(fill_rd) + cnt_x;

    always_comb begin
        n_state      = r_state;
        n_cmd        = r_cmd;
        n_fill       = r_fill;
        n_src_fill   = r_src_fill;
        n_dst_fill   = r_dst_fill;
        n_left       = r_left;
        n_wr_pend    = r_wr_pend;
        n_scan       = r_scan;
        n_hit        = r_hit;
        n_hit_stack  = r_hit_stack;
        n_pend_valid = r_pend_valid;
        n_pend_value = r_pend_value;
        n_pend_stack = r_pend_stack;
        n_out_valid  = 1'b0;
        n_out_status = STS_OK;
        n_out_value  = '0;
        n_out_stack  = '0;
        n_out_last   = 1'b1;
        o_pop        = 1'b0;
        fill_idx     = '0;
        rd_addr      = '0;
        we           = 1'b0;
        wr_addr      = '0;
        wr_data      = '0;

        // A top read issued last cycle is now in r_rd_data. The previous hit is
        // released as a non-final result; the newest one waits as pending.
        if ((r_state == S_RT_SCAN || r_state == S_RT_FLUSH) && r_hit) begin
            if (r_pend_valid) begin
                n_out_valid = 1'b1;
                n_out_value = r_pend_value;
                n_out_stack = IDX_W'(r_pend_stack);
                n_out_last  = 1'b0;
            end
            n_pend_valid = 1'b1;
            n_pend_value = r_rd_data;
            n_pend_stack = r_hit_stack;
        end

        unique case (r_state)
            S_IDLE: begin
                if (!i_empty) begin
                    o_pop = 1'b1;
                    n_cmd = i_cmd;
                    unique case (i_cmd.kind)
                        CMD_BAD: begin
                            n_out_valid  = 1'b1;
                            n_out_status = STS_BAD_INDEX;
                        end
                        CMD_PUSH: n_state = S_PUSH;
                        CMD_MOVE: n_state = S_MV_SRC;
                        CMD_TOPS: begin
                            n_scan       = '0;
                            n_hit        = 1'b0;
                            n_pend_valid = 1'b0;
                            n_state      = S_RT_SCAN;
                        end
                    endcase
                end
            end
            S_PUSH: begin
                fill_idx    = src_row;
                n_out_valid = 1'b1;
                if (fill_rd >= DEPTH_F) begin
                    n_out_status = STS_FULL;
                end else begin
                    we               = 1'b1;
                    wr_addr          = {src_row, fill_rd[OW-1:0]};
                    wr_data          = r_cmd.value;
                    n_fill[src_row]  = fill_rd + FW'(1);
                end
                n_state = S_IDLE;
            end
            S_MV_SRC: begin
                fill_idx   = src_row;
                n_src_fill = fill_rd;
                n_state    = S_MV_DST;
            end
            S_MV_DST: begin
                fill_idx   = dst_row;
                n_dst_fill = fill_rd;
                n_left     = r_cmd.count;
                n_wr_pend  = 1'b0;
                n_state    = S_IDLE;
                // Order matters: too few elements outranks the same-stack case.
                priority if (cnt_x > XW'(r_src_fill)) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STS_TOO_FEW;
                end else if (r_cmd.src == r_cmd.dst || r_cmd.count == '0) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STS_OK;
                end else if (dst_sum > DEPTH_X) begin
                    n_out_valid  = 1'b1;
                    n_out_status = STS_FULL;
                end else begin
                    n_state = S_MV_LOOP;
                end
            end
            S_MV_LOOP: begin
                // Pop one element per cycle; its byte lands on the destination
                // in the following cycle, overlapped with the next pop.
                if (r_left != '0) begin
                    rd_addr    = {src_row, src_dec[OW-1:0]};
                    n_src_fill = src_dec;
                    n_left     = r_left - CNT_W'(1);
                    n_wr_pend  = 1'b1;
                end else begin
                    n_wr_pend  = 1'b0;
                    n_state    = S_MV_WB;
                end
                if (r_wr_pend) begin
                    we         = 1'b1;
                    wr_addr    = {dst_row, r_dst_fill[OW-1:0]};
                    wr_data    = r_rd_data;
                    n_dst_fill = r_dst_fill + FW'(1);
                end
            end
            S_MV_WB: begin
                n_fill[src_row] = r_src_fill;
                n_fill[dst_row] = r_dst_fill;
                n_out_valid     = 1'b1;
                n_state         = S_IDLE;
            end
            S_RT_SCAN: begin
                fill_idx = r_scan;
                if (fill_rd != '0) begin
                    rd_addr     = {r_scan, fill_dec[OW-1:0]};
                    n_hit       = 1'b1;
                    n_hit_stack = r_scan;
                end else begin
                    n_hit = 1'b0;
                end
                if (r_scan == LAST_ROW) begin
                    n_state = S_RT_FLUSH;
                end else begin
                    n_scan = r_scan + RW'(1);
                end
            end
            S_RT_FLUSH: begin
                // The last hit, if any, is folded into pending above; the final
                // result goes out on the first pass here with no hit left.
                n_hit = 1'b0;
                if (!r_hit) begin
                    n_out_valid = 1'b1;
                    if (r_pend_valid) begin
                        n_out_value = r_pend_value;
                        n_out_stack = IDX_W'(r_pend_stack);
                    end else begin
                        n_out_status = STS_NO_DATA;
                    end
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_left       <= '0;
            r_wr_pend    <= 1'b0;
            r_hit        <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
            for (int i = 0; i < NUM_ADDR; i++) begin
                r_fill[i] <= '0;
            end
        end else begin
            r_state      <= n_state;
            r_left       <= n_left;
            r_wr_pend    <= n_wr_pend;
            r_hit        <= n_hit;
            r_pend_valid <= n_pend_valid;
            r_out_valid  <= n_out_valid;
            r_fill       <= n_fill;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_src_fill   <= n_src_fill;
        r_dst_fill   <= n_dst_fill;
        r_scan       <= n_scan;
        r_hit_stack  <= n_hit_stack;
        r_pend_value <= n_pend_value;
        r_pend_stack <= n_pend_stack;
        r_out_status <= n_out_status;
        r_out_value  <= n_out_value;
        r_out_stack  <= n_out_stack;
        r_out_last   <= n_out_last;
    end

    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        r_rd_data <= mem[rd_addr];
    end

    assign o_strobe    = r_out_valid;
    assign o_status    = r_out_status;
    assign o_top_value = r_out_value;
    assign o_top_stack = r_out_stack;
    assign o_last      = r_out_last;

    `MSBM_ASSERT_IMP(a_pop_idle, o_pop, r_state == S_IDLE && !i_empty, "pop outside idle")
    `MSBM_ASSERT_IMP(a_mid_only_tops, r_out_valid && !r_out_last,
        r_state == S_RT_SCAN || r_state == S_RT_FLUSH, "non-final result outside top read")
    `MSBM_ASSERT_IMP(a_src_no_underflow, r_state == S_MV_LOOP && r_left != '0,
        r_src_fill != '0, "move pops an empty source")
    `MSBM_ASSERT_NXT(a_move_done_ok, r_state == S_MV_WB,
        r_out_valid && r_out_status == STS_OK && r_out_last, "move finish without ok result")

endmodule

>>> rtl/multi_stack_bank_with_move.sv
// ----------------------------------------------------------------------------
// Multi-stack bank with move
// Bank of byte stacks in one store with push, block move and read-tops.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; up to two items queue
// ahead of the engine. Results appear for one cycle with o_strobe and cannot
// be held off. A move carries one byte per cycle, since the store has one
// read and one write port. A read-tops item visits every addressable stack
// once. A failing push or move leaves the bank unchanged. No clearing pass
// follows reset: the fill counts reset to zero and the store needs none.
module multi_stack_bank_with_move import msbm_pkg::*; #(
    parameter int NUM_STACKS  = NUM_STACKS_DEF,
    parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  logic [OP_W-1:0]   i_operation,
    input  logic [IDX_W-1:0]  i_first_stack,
    input  logic [IDX_W-1:0]  i_second_stack,
    input  logic [CNT_W-1:0]  i_move_count,
    input  logic [VAL_W-1:0]  i_push_value,
    output logic              o_strobe,
    output logic [STS_W-1:0]  o_status,
    output logic [VAL_W-1:0]  o_top_value,
    output logic [IDX_W-1:0]  o_top_stack,
    output logic              o_last
);

    t_cmd  front_cmd;
    t_cmd  queue_cmd;
    logic  queue_push;
    logic  queue_pop;
    logic  queue_full;
    logic  queue_empty;

    msbm_front #(
        .NUM_STACKS (NUM_STACKS)
    ) u_front (
        .start          (start),
        .i_full         (queue_full),
        .i_operation    (i_operation),
        .i_first_stack  (i_first_stack),
        .i_second_stack (i_second_stack),
        .i_move_count   (i_move_count),
        .i_push_value   (i_push_value),
        .o_push         (queue_push),
        .o_cmd          (front_cmd)
    );

    msbm_cmd_fifo u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (queue_push),
        .i_cmd   (front_cmd),
        .i_pop   (queue_pop),
        .o_cmd   (queue_cmd),
        .o_full  (queue_full),
        .o_empty (queue_empty)
    );

    msbm_engine #(
        .NUM_STACKS  (NUM_STACKS),
        .STACK_DEPTH (STACK_DEPTH)
    ) u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (queue_cmd),
        .i_empty     (queue_empty),
        .o_pop       (queue_pop),
        .o_strobe    (o_strobe),
        .o_status    (o_status),
        .o_top_value (o_top_value),
        .o_top_stack (o_top_stack),
        .o_last      (o_last)
    );

    assign busy = queue_full;

endmodule

>>> bench/tb_multi_stack_bank_with_move.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Multi-stack bank with move testbench
// Sends push, move and read-tops items to the stack bank and checks every
// result against a bank model kept here. It runs a short directed part, a
// test that drives one stack to full, and random traffic under three sender
// idling profiles.
// ----------------------------------------------------------------------------
module tb_multi_stack_bank_with_move;
    import msbm_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int TAIL_CYCLES = 200;
    localparam int MAX_REPORTS = 10;

    // The one operation code that the block ignores.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    typedef struct {
        t_status           status;
        logic [VAL_W-1:0]  value;
        logic [IDX_W-1:0]  stack;
        logic              last;
    } t_stack_report;

    logic              i_clk;
    logic              i_rst_n;
    logic              start;
    logic              busy;
    logic [OP_W-1:0]   i_operation;
    logic [IDX_W-1:0]  i_first_stack;
    logic [IDX_W-1:0]  i_second_stack;
    logic [CNT_W-1:0]  i_move_count;
    logic [VAL_W-1:0]  i_push_value;
    logic              o_strobe;
    logic [STS_W-1:0]  o_status;
    logic [VAL_W-1:0]  o_top_value;
    logic [IDX_W-1:0]  o_top_stack;
    logic              o_last;

    // Bank model: contents and fill count of every stack.
    logic [VAL_W-1:0]  bank_data [NUM_STACKS_DEF][STACK_DEPTH_DEF];
    int                bank_fill [NUM_STACKS_DEF];

    t_stack_report     expected_reports[$];
    int                mismatch_count;
    int                cycle_count;
    int                idle_pct;

    multi_stack_bank_with_move DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_operation    (i_operation),
        .i_first_stack  (i_first_stack),
        .i_second_stack (i_second_stack),
        .i_move_count   (i_move_count),
        .i_push_value   (i_push_value),
        .o_strobe       (o_strobe),
        .o_status       (o_status),
        .o_top_value    (o_top_value),
        .o_top_stack    (o_top_stack),
        .o_last         (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Works out the results of one accepted item and updates the bank model.
    function automatic void predict_bank_results(logic [OP_W-1:0] op,
                                                 logic [IDX_W-1:0] first,
                                                 logic [IDX_W-1:0] second,
                                                 logic [CNT_W-1:0] count,
                                                 logic [VAL_W-1:0] value);
        t_stack_report rep;
        int            last_idx;
        logic [VAL_W-1:0] moved;
        rep = '{STS_OK, '0, '0, 1'b1};
        case (op)
            OP_PUSH: begin
                if (first >= NUM_STACKS_DEF) begin
                    rep.status = STS_BAD_INDEX;
                end else if (bank_fill[first] >= STACK_DEPTH_DEF) begin
                    rep.status = STS_FULL;
                end else begin
                    bank_data[first][bank_fill[first]] = value;
                    bank_fill[first]++;
                end
                expected_reports.push_back(rep);
            end
            OP_MOVE: begin
                if (first >= NUM_STACKS_DEF || second >= NUM_STACKS_DEF) begin
                    rep.status = STS_BAD_INDEX;
                end else if (count > bank_fill[first]) begin
                    rep.status = STS_TOO_FEW;
                end else if (first == second) begin
                    rep.status = STS_OK;
                end else if (bank_fill[second] + count > STACK_DEPTH_DEF) begin
                    rep.status = STS_FULL;
                end else begin
                    // Bytes go over one at a time, so the block lands reversed.
                    for (int k = 0; k < count; k++) begin
                        bank_fill[first]--;
                        moved = bank_data[first][bank_fill[first]];
                        bank_data[second][bank_fill[second]] = moved;
                        bank_fill[second]++;
                    end
                end
                expected_reports.push_back(rep);
            end
            OP_TOPS: begin
                last_idx = -1;
                for (int s = 0; s < NUM_STACKS_DEF && s < IDX_SPAN; s++) begin
                    if (bank_fill[s] != 0) last_idx = s;
                end
                if (last_idx < 0) begin
                    rep.status = STS_NO_DATA;
                    expected_reports.push_back(rep);
                end else begin
                    for (int s = 0; s <= last_idx; s++) begin
                        if (bank_fill[s] != 0) begin
                            rep.status = STS_OK;
                            rep.value  = bank_data[s][bank_fill[s] - 1];
                            rep.stack  = IDX_W'(s);
                            rep.last   = (s == last_idx);
                            expected_reports.push_back(rep);
                        end
                    end
                end
            end
            default: begin
                // The unused operation code gives no result.
            end
        endcase
    endfunction

    always @(posedge i_clk) begin
        t_stack_report exp_rep;
        if (i_rst_n && o_strobe) begin
            if (expected_reports.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("MISMATCH at %0t: unexpected result", $realtime);
                    $display("    got status=%0d value=%0d stack=%0d last=%0d",
                             o_status, o_top_value, o_top_stack, o_last);
                end
            end else begin
                exp_rep = expected_reports.pop_front();
                if (o_status !== exp_rep.status || o_top_value !== exp_rep.value ||
                    o_top_stack !== exp_rep.stack || o_last !== exp_rep.last) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("MISMATCH at %0t: expected status=%0d value=%0d %s%0d %s%0d",
                                 $realtime, exp_rep.status, exp_rep.value, "stack=",
                                 exp_rep.stack, "last=", exp_rep.last);
                        $display("    got status=%0d value=%0d stack=%0d last=%0d",
                                 o_status, o_top_value, o_top_stack, o_last);
                    end
                end
            end
        end
    end

    // Sends one item, with random idle cycles ahead of it, and returns at the
    // edge that accepts it.
    task automatic send_item(logic [OP_W-1:0] op, logic [IDX_W-1:0] first,
                             logic [IDX_W-1:0] second, logic [CNT_W-1:0] count,
                             logic [VAL_W-1:0] value);
        while ($urandom_range(99) < idle_pct) begin
            @(negedge i_clk);
            start = 1'b0;
        end
        @(negedge i_clk);
        start          = 1'b1;
        i_operation    = op;
        i_first_stack  = first;
        i_second_stack = second;
        i_move_count   = count;
        i_push_value   = value;
        do @(posedge i_clk); while (busy);
        predict_bank_results(op, first, second, count, value);
    endtask

    task automatic push_byte(int stack_idx, logic [VAL_W-1:0] value);
        send_item(OP_PUSH, IDX_W'(stack_idx), IDX_W'($urandom_range(15)),
                  CNT_W'($urandom_range(255)), value);
    endtask

    task automatic move_bytes(int src, int dst, int count);
        send_item(OP_MOVE, IDX_W'(src), IDX_W'(dst), CNT_W'(count),
                  VAL_W'($urandom_range(255)));
    endtask

    task automatic read_tops();
        send_item(OP_TOPS, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
                  CNT_W'($urandom_range(255)), VAL_W'($urandom_range(255)));
    endtask

    // Holds the sender off until every expected result has come back.
    task automatic wait_for_drain();
        @(negedge i_clk);
        start = 1'b0;
        while (expected_reports.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed_ops();
        read_tops();                        // every stack empty
        send_item(OP_UNUSED, 4'hF, 4'h0, 8'hFF, 8'h00);
        push_byte(0, 8'h00);
        push_byte(15, 8'hFF);
        push_byte(0, 8'hA5);
        push_byte(0, 8'h5A);
        move_bytes(0, 1, 0);                // zero count
        move_bytes(15, 15, 1);              // same stack
        move_bytes(0, 1, 3);                // whole stack, reversed
        move_bytes(1, 2, 4);                // one more than the source holds
        move_bytes(5, 6, 0);                // zero count from an empty stack
        move_bytes(3, 3, 1);                // same stack, too few
        read_tops();
        move_bytes(1, 0, 255);
        move_bytes(1, 14, 2);
        push_byte(14, 8'h3C);
        read_tops();
        move_bytes(14, 0, 3);
        read_tops();
    endtask

    // Fills one stack to the top, then hits the full cases from both sides.
    task automatic test_full_stack();
        int tgt;
        int donor;
        int dest;
        tgt   = $urandom_range(15);
        donor = (tgt + 1) % NUM_STACKS_DEF;
        while (bank_fill[tgt] < STACK_DEPTH_DEF) push_byte(tgt, VAL_W'($urandom_range(255)));
        push_byte(tgt, VAL_W'($urandom_range(255)));
        if (bank_fill[donor] == 0) push_byte(donor, VAL_W'($urandom_range(255)));
        move_bytes(donor, tgt, 1);
        move_bytes(tgt, tgt, STACK_DEPTH_DEF);
        read_tops();
        dest = donor;
        for (int s = 0; s < NUM_STACKS_DEF; s++) begin
            if (s != tgt && bank_fill[s] < bank_fill[dest]) dest = s;
        end
        move_bytes(tgt, dest, STACK_DEPTH_DEF - bank_fill[dest]);
        move_bytes(dest, tgt, 1);
        read_tops();
    endtask

    // Mostly stacks 0 to 3, so that fills grow deep enough to matter.
    function automatic int pick_stack();
        if ($urandom_range(99) < 70) return $urandom_range(3);
        return $urandom_range(NUM_STACKS_DEF - 1);
    endfunction

    task automatic test_random_traffic(int n_items);
        int done;
        int pick;
        int src;
        int dst;
        done = 0;
        while (done < n_items) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                push_byte(pick_stack(), VAL_W'($urandom_range(255)));
                done++;
            end else if (pick < 80) begin
                src = pick_stack();
                dst = pick_stack();
                if ($urandom_range(99) < 85)
                    move_bytes(src, dst, $urandom_range(bank_fill[src]));
                else
                    move_bytes(src, dst, $urandom_range(255));
                done++;
            end else if (pick < 95) begin
                read_tops();
                done++;
            end else begin
                send_item(OP_UNUSED, IDX_W'($urandom_range(15)), IDX_W'($urandom_range(15)),
                          CNT_W'($urandom_range(255)), VAL_W'($urandom_range(255)));
            end
            if ($urandom_range(99) < 2) wait_for_drain();
        end
    endtask

    initial begin
        mismatch_count = 0;
        cycle_count    = 0;
        idle_pct       = 15;
        for (int s = 0; s < NUM_STACKS_DEF; s++) bank_fill[s] = 0;
        i_rst_n        = 1'b0;
        start          = 1'b0;
        i_operation    = '0;
        i_first_stack  = '0;
        i_second_stack = '0;
        i_move_count   = '0;
        i_push_value   = '0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed_ops();
        test_random_traffic(10);
        wait_for_drain();

        idle_pct = 84;
        test_full_stack();
        test_random_traffic(10);
        wait_for_drain();

        idle_pct = 0;
        test_random_traffic(10);
        wait_for_drain();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (expected_reports.size() != 0) begin
            mismatch_count++;
            $display("MISMATCH: %0d expected results never came", expected_reports.size());
        end
        if (mismatch_count == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

>>> multi_stack_bank_with_move.f
+incdir+rtl
rtl/msbm_pkg.sv
rtl/msbm_front.sv
rtl/msbm_cmd_fifo.sv
rtl/msbm_engine.sv
rtl/multi_stack_bank_with_move.sv
bench/tb_multi_stack_bank_with_move.sv
